// File: sv/boxds_pkg.sv
// Shared types, constants and width helpers for the box-average downscaler.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package boxds_pkg;

  // Default values of the top-level parameters.
  localparam int unsigned DEF_MAX_WIDTH  = 2048;
  localparam int unsigned DEF_MAX_FACTOR = 16;
  localparam int unsigned DEF_CHANNELS   = 4;

  // Fixed payload and register geometry.
  localparam int unsigned NUM_CH        = 4;
  localparam int unsigned SAMPLE_W      = 8;
  localparam int unsigned COORD_W       = 10;
  localparam int unsigned CFG_DATA_W    = 12;
  localparam int unsigned CFG_IDX_W     = 2;
  localparam int unsigned FACTOR_REG_W  = 5;
  localparam int unsigned CHAN_W        = 3;
  localparam int unsigned HEIGHT_W      = 12;
  localparam int unsigned HEIGHT_LIMIT  = 2048;
  localparam int unsigned ROW_W         = 11;
  localparam int unsigned QUEUE_DEPTH   = 2;

  // The divider produces one quotient bit per step.
  localparam int unsigned QUOT_W   = SAMPLE_W;
  localparam int unsigned STEP_W   = 3;
  localparam logic [STEP_W-1:0] STEP_MAX = STEP_W'(QUOT_W - 1);

  // Register values after reset.
  localparam int unsigned RST_WIDTH    = 640;
  localparam int unsigned RST_HEIGHT   = 480;
  localparam int unsigned RST_FACTOR   = 2;
  localparam int unsigned RST_CHANNELS = 4;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH    = 2'd0,
    REG_HEIGHT   = 2'd1,
    REG_FACTOR   = 2'd2,
    REG_CHANNELS = 2'd3
  } cfg_reg_e;

  // Back-end sequencer states.
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_DONE
  } back_state_e;

  // One incoming pixel.
  typedef struct packed {
    logic [SAMPLE_W-1:0] pixel_ch0;
    logic [SAMPLE_W-1:0] pixel_ch1;
    logic [SAMPLE_W-1:0] pixel_ch2;
    logic [SAMPLE_W-1:0] pixel_ch3;
  } pixel_t;

  // One downscaled output pixel.
  typedef struct packed {
    logic [SAMPLE_W-1:0] out_ch0;
    logic [SAMPLE_W-1:0] out_ch1;
    logic [SAMPLE_W-1:0] out_ch2;
    logic [SAMPLE_W-1:0] out_ch3;
    logic [COORD_W-1:0]  out_x;
    logic [COORD_W-1:0]  out_y;
    logic                last_of_frame;
  } result_t;

  // Width of one channel's block sum for a given largest factor.
  function automatic int unsigned sum_w(input int unsigned max_factor);
    return $clog2(max_factor * max_factor * 255 + 1);
  endfunction

  // Width of one queue entry: four block sums, coordinates and the frame flag.
  function automatic int unsigned entry_w(input int unsigned max_factor);
    return NUM_CH * sum_w(max_factor) + 2 * COORD_W + 1;
  endfunction

endpackage

`default_nettype wire

// File: sv/boxds_queue.sv
// Small register FIFO that decouples the accumulating front from the divider.
// Depends on boxds_pkg only through the common import convention.
`default_nettype none

module boxds_queue #(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned DEPTH  = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic [DATA_W-1:0] pop_data_o,
  output logic              empty_o
);
  import boxds_pkg::*;

  localparam int unsigned PW    = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] entry_q [DEPTH];
  logic [PW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]  count_q, count_d;

  // Fill status.
  assign full_o     = (count_q == CNT_W'(DEPTH));
  assign empty_o    = (count_q == '0);
  assign pop_data_o = entry_q[rd_ptr_q];

  // Pointer and count updates.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CNT_W'(1);
    end else if (!push_i && pop_i) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  // The front must hold off while the queue is full, the back while it is empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !full_o)
    else $error("queue pushed while full");
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> !empty_o)
    else $error("queue popped while empty");

endmodule

`default_nettype wire

// File: sv/boxds_front.sv
// Front end: raster position tracking, run and column sums, and block completion.
// Depends on boxds_pkg; pushes finished block sums into boxds_queue.
`default_nettype none

module boxds_front #(
  parameter int unsigned MAX_WIDTH  = boxds_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_FACTOR = boxds_pkg::DEF_MAX_FACTOR
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         restart_i,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]               width_i,
  input  logic [boxds_pkg::HEIGHT_W-1:0]               height_i,
  input  logic [$clog2(MAX_FACTOR+1)-1:0]              factor_i,
  input  logic [boxds_pkg::CHAN_W-1:0]                 chan_i,
  input  logic                                         in_valid_i,
  output logic                                         in_stall_o,
  input  boxds_pkg::pixel_t                            in_data_i,
  input  logic                                         q_full_i,
  output logic                                         q_push_o,
  output logic [boxds_pkg::entry_w(MAX_FACTOR)-1:0]    q_data_o
);
  import boxds_pkg::*;

  localparam int unsigned WW        = $clog2(MAX_WIDTH + 1);
  localparam int unsigned XW        = $clog2(MAX_WIDTH);
  localparam int unsigned FW        = $clog2(MAX_FACTOR + 1);
  localparam int unsigned BW        = $clog2(MAX_FACTOR);
  localparam int unsigned SUM_DEPTH = MAX_WIDTH / 2;
  localparam int unsigned CW        = $clog2(SUM_DEPTH);
  localparam int unsigned RW        = $clog2(MAX_FACTOR * 255 + 1);
  localparam int unsigned SW        = sum_w(MAX_FACTOR);
  localparam int unsigned EW        = ((WW > FW) ? WW : FW) + 2;
  localparam int unsigned HE        = ((HEIGHT_W > FW) ? HEIGHT_W : FW) + 2;
  localparam int unsigned MEM_W     = NUM_CH * SW;

  // Position counters.
  logic [XW-1:0]      in_col_q, in_col_d;
  logic [ROW_W-1:0]   in_row_q, in_row_d;
  logic [BW-1:0]      cib_q, cib_d;
  logic [BW-1:0]      rib_q, rib_d;
  logic [CW-1:0]      out_col_q, out_col_d;
  logic [COORD_W-1:0] out_row_q, out_row_d;
  logic [RW-1:0]      run_q [NUM_CH];
  logic [RW-1:0]      run_d [NUM_CH];

  // Column sum memory and its registered read port.
  logic [MEM_W-1:0]   mem [SUM_DEPTH];
  logic [MEM_W-1:0]   rd_q;
  logic [MEM_W-1:0]   mem_wdata;
  logic               mem_we;

  logic [SAMPLE_W-1:0] pix [NUM_CH];
  logic [RW-1:0]       run_new [NUM_CH];
  logic [SW-1:0]       blk [NUM_CH];

  logic [EW-1:0] col_e, w_e, fc_e, cib_e;
  logic [HE-1:0] row_e, h_e, fr_e, rib_e;
  logic          col_ok, row_ok, col_last, row_last, active;
  logic          cib_last, rib_last, at_row_end, at_frame_end, acc;
  logic [CW+COORD_W-1:0] ox_wide;

  assign pix[0] = in_data_i.pixel_ch0;
  assign pix[1] = in_data_i.pixel_ch1;
  assign pix[2] = in_data_i.pixel_ch2;
  assign pix[3] = in_data_i.pixel_ch3;

  // Hold pixels back while the queue has no room for a result.
  assign in_stall_o = q_full_i;
  assign acc        = in_valid_i && !in_stall_o;

  // Classify the current position against the whole-block area.
  always_comb begin
    col_e = EW'(in_col_q);
    w_e   = EW'(width_i);
    fc_e  = EW'(factor_i);
    cib_e = EW'(cib_q);
    row_e = HE'(in_row_q);
    h_e   = HE'(height_i);
    fr_e  = HE'(factor_i);
    rib_e = HE'(rib_q);

    // A block is whole when its first column plus f stays within the width.
    col_ok   = (col_e - cib_e + fc_e) <= w_e;
    row_ok   = (row_e - rib_e + fr_e) <= h_e;
    // The last whole block is the one after which no further block fits.
    col_last = (col_e + EW'(1) + fc_e) > w_e;
    row_last = (row_e + HE'(1) + fr_e) > h_e;
    active   = col_ok && row_ok;

    cib_last     = (cib_e == fc_e - EW'(1));
    rib_last     = (rib_e == fr_e - HE'(1));
    at_row_end   = (col_e >= w_e - EW'(1));
    at_frame_end = (row_e >= h_e - HE'(1));
  end

  // Per-channel run sums and block sums.
  always_comb begin
    for (int k = 0; k < NUM_CH; k++) begin
      run_new[k] = run_q[k] + ((CHAN_W'(k) < chan_i) ? RW'(pix[k]) : RW'(0));
      if (rib_q == '0) begin
        blk[k] = SW'(run_new[k]);
      end else begin
        blk[k] = rd_q[k*SW +: SW] + SW'(run_new[k]);
      end
    end
  end

  // Intermediate rows go to the column memory, the bottom row goes to the queue.
  assign mem_we   = acc && active && cib_last && !rib_last;
  assign q_push_o = acc && active && cib_last && rib_last;
  assign ox_wide  = (CW+COORD_W)'(out_col_q);

  always_comb begin
    mem_wdata = '0;
    q_data_o  = '0;
    for (int k = 0; k < NUM_CH; k++) begin
      mem_wdata[k*SW +: SW]                = blk[k];
      q_data_o[2*COORD_W + 1 + k*SW +: SW] = blk[k];
    end
    q_data_o[2*COORD_W:COORD_W+1] = ox_wide[COORD_W-1:0];
    q_data_o[COORD_W:1]           = out_row_q;
    q_data_o[0]                   = col_last && row_last;
  end

  // Raster position advance.
  always_comb begin
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    cib_d     = cib_q;
    rib_d     = rib_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    run_d     = run_q;
    if (restart_i) begin
      in_col_d  = '0;
      in_row_d  = '0;
      cib_d     = '0;
      rib_d     = '0;
      out_col_d = '0;
      out_row_d = '0;
      run_d     = '{default: '0};
    end else if (acc) begin
      if (active) begin
        run_d = run_new;
        if (cib_last) begin
          run_d = '{default: '0};
        end
      end
      if (at_row_end) begin
        in_col_d  = '0;
        cib_d     = '0;
        out_col_d = '0;
        run_d     = '{default: '0};
        if (at_frame_end) begin
          in_row_d  = '0;
          rib_d     = '0;
          out_row_d = '0;
        end else begin
          in_row_d = in_row_q + ROW_W'(1);
          if (rib_last) begin
            rib_d     = '0;
            out_row_d = out_row_q + COORD_W'(1);
          end else begin
            rib_d = rib_q + BW'(1);
          end
        end
      end else begin
        in_col_d = in_col_q + XW'(1);
        if (cib_last) begin
          cib_d     = '0;
          out_col_d = out_col_q + CW'(1);
        end else begin
          cib_d = cib_q + BW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      cib_q     <= '0;
      rib_q     <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      run_q     <= '{default: '0};
    end else begin
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      cib_q     <= cib_d;
      rib_q     <= rib_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
      run_q     <= run_d;
    end
  end

  // The read port follows the current output column, so the stored partial
  // sum is ready by the time the block's last pixel arrives.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[out_col_q] <= mem_wdata;
    end
    rd_q <= mem[out_col_q];
  end

  // Block-relative counters stay inside the current factor.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (FW'(cib_q) < factor_i) && (FW'(rib_q) < factor_i))
    else $error("block-relative counter outside the factor");

endmodule

`default_nettype wire

// File: sv/boxds_back.sv
// Back end: divides each block sum by f*f one quotient bit per cycle and
// holds the result in the output register. Depends on boxds_pkg.
`default_nettype none

module boxds_back #(
  parameter int unsigned MAX_FACTOR = boxds_pkg::DEF_MAX_FACTOR
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic [$clog2(MAX_FACTOR*MAX_FACTOR+1)-1:0]   fsq_i,
  input  logic                                         q_empty_i,
  output logic                                         q_pop_o,
  input  logic [boxds_pkg::entry_w(MAX_FACTOR)-1:0]    q_data_i,
  output logic                                         out_valid_o,
  input  logic                                         out_stall_i,
  output boxds_pkg::result_t                           out_data_o
);
  import boxds_pkg::*;

  localparam int unsigned SW = sum_w(MAX_FACTOR);

  back_state_e         state_q, state_d;
  logic [STEP_W-1:0]   step_q;
  logic                out_valid_q;
  logic [SW-1:0]       rem_q  [NUM_CH];
  logic [QUOT_W-1:0]   quot_q [NUM_CH];
  logic [COORD_W-1:0]  x_q, y_q;
  logic                last_q;
  result_t             out_q;

  logic                div_step, out_load, out_free;
  logic [SW-1:0]       dvs;
  logic [SW-1:0]       dsh;
  logic [NUM_CH-1:0]   ge;

  assign out_free = !out_valid_q || !out_stall_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: if (!q_empty_i) state_d = BK_DIV;
      BK_DIV:  if (step_q == '0) state_d = BK_DONE;
      BK_DONE: if (out_free) state_d = BK_IDLE;
      default: state_d = BK_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    q_pop_o  = 1'b0;
    div_step = 1'b0;
    out_load = 1'b0;
    case (state_q)
      BK_IDLE: q_pop_o  = !q_empty_i;
      BK_DIV:  div_step = 1'b1;
      BK_DONE: out_load = out_free;
      default: ;
    endcase
  end

  // Restoring divide step: compare against the divisor shifted to this bit.
  always_comb begin
    dvs = SW'(fsq_i);
    dsh = dvs << step_q;
    for (int k = 0; k < NUM_CH; k++) begin
      ge[k] = (rem_q[k] >= dsh);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (q_pop_o) begin
        step_q <= STEP_MAX;
      end else if (div_step && step_q != '0) begin
        step_q <= step_q - STEP_W'(1);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Divider datapath and output register.
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      for (int k = 0; k < NUM_CH; k++) begin
        rem_q[k]  <= q_data_i[2*COORD_W + 1 + k*SW +: SW];
        quot_q[k] <= '0;
      end
      x_q    <= q_data_i[2*COORD_W:COORD_W+1];
      y_q    <= q_data_i[COORD_W:1];
      last_q <= q_data_i[0];
    end else if (div_step) begin
      for (int k = 0; k < NUM_CH; k++) begin
        if (ge[k]) begin
          rem_q[k]         <= rem_q[k] - dsh;
          quot_q[k][step_q] <= 1'b1;
        end
      end
    end
    if (out_load) begin
      out_q.out_ch0       <= quot_q[0];
      out_q.out_ch1       <= quot_q[1];
      out_q.out_ch2       <= quot_q[2];
      out_q.out_ch3       <= quot_q[3];
      out_q.out_x         <= x_q;
      out_q.out_y         <= y_q;
      out_q.last_of_frame <= last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A popped entry always starts a full-length division.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |=> (state_q == BK_DIV) && (step_q == STEP_MAX))
    else $error("division did not start from the top quotient bit");
  // After the last step every remainder lies below the divisor.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_DONE) |-> (rem_q[0] < dvs) && (rem_q[1] < dvs) &&
                             (rem_q[2] < dvs) && (rem_q[3] < dvs))
    else $error("remainder not below divisor after division");

endmodule

`default_nettype wire

// File: sv/box_average_downscaler.sv
// Path: a finished block sum goes through the queue, the divider and the output register.
// Throughput: one pixel per cycle until the input stalls; the bit-serial divider finishes
// each output pixel before it takes the next, and a two-entry queue absorbs results.
// Reset: registers return to 640x480, factor 2, four channels; the frame restarts.
// Any configuration write also restarts the frame at its top-left pixel.
// Depends on boxds_pkg, boxds_front, boxds_queue and boxds_back.
`default_nettype none

module box_average_downscaler #(
  parameter int unsigned MAX_WIDTH  = boxds_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_FACTOR = boxds_pkg::DEF_MAX_FACTOR,
  parameter int unsigned CHANNELS   = boxds_pkg::DEF_CHANNELS
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  boxds_pkg::pixel_t                  in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output boxds_pkg::result_t                 out_data_o,
  input  logic                               cfg_we_i,
  input  logic [boxds_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [boxds_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import boxds_pkg::*;

  localparam int unsigned WW      = $clog2(MAX_WIDTH + 1);
  localparam int unsigned FW      = $clog2(MAX_FACTOR + 1);
  localparam int unsigned DW      = $clog2(MAX_FACTOR * MAX_FACTOR + 1);
  localparam int unsigned ENTRY_W = entry_w(MAX_FACTOR);

  // Register value clamps to the supported ranges.
  function automatic logic [WW-1:0] clamp_width(input logic [CFG_DATA_W-1:0] v);
    logic [31:0] x;
    x = 32'(v);
    if (x < 32'd2) return WW'(2);
    if (x > MAX_WIDTH) return WW'(MAX_WIDTH);
    return WW'(x);
  endfunction

  function automatic logic [HEIGHT_W-1:0] clamp_height(input logic [CFG_DATA_W-1:0] v);
    logic [31:0] x;
    x = 32'(v);
    if (x < 32'd2) return HEIGHT_W'(2);
    if (x > HEIGHT_LIMIT) return HEIGHT_W'(HEIGHT_LIMIT);
    return HEIGHT_W'(x);
  endfunction

  function automatic logic [FW-1:0] clamp_factor(input logic [CFG_DATA_W-1:0] v);
    logic [31:0] x;
    x = 32'(v[FACTOR_REG_W-1:0]);
    if (x < 32'd2) return FW'(2);
    if (x > MAX_FACTOR) return FW'(MAX_FACTOR);
    return FW'(x);
  endfunction

  function automatic logic [CHAN_W-1:0] clamp_chan(input logic [CFG_DATA_W-1:0] v);
    logic [31:0] x;
    x = 32'(v[CHAN_W-1:0]);
    if (x < 32'd1) return CHAN_W'(1);
    if (x > CHANNELS) return CHAN_W'(CHANNELS);
    return CHAN_W'(x);
  endfunction

  function automatic logic [DW-1:0] square_factor(input logic [FW-1:0] fv);
    logic [2*FW-1:0] t;
    t = (2*FW)'(fv);
    t = t * t;
    return DW'(t);
  endfunction

  localparam logic [WW-1:0]       WIDTH_RST  = clamp_width(CFG_DATA_W'(RST_WIDTH));
  localparam logic [HEIGHT_W-1:0] HEIGHT_RST = clamp_height(CFG_DATA_W'(RST_HEIGHT));
  localparam logic [FW-1:0]       FACTOR_RST = clamp_factor(CFG_DATA_W'(RST_FACTOR));
  localparam logic [CHAN_W-1:0]   CHAN_RST   = clamp_chan(CFG_DATA_W'(RST_CHANNELS));

  logic [WW-1:0]       width_q;
  logic [HEIGHT_W-1:0] height_q;
  logic [FW-1:0]       factor_q;
  logic [CHAN_W-1:0]   chan_q;
  logic [DW-1:0]       fsq_q;
  logic [FW-1:0]       factor_new;

  logic                q_push, q_full, q_pop, q_empty;
  logic [ENTRY_W-1:0]  q_push_data, q_pop_data;

  assign factor_new = clamp_factor(cfg_data_i);

  // Configuration registers, kept already clamped; f*f is kept for the divider.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
      factor_q <= FACTOR_RST;
      chan_q   <= CHAN_RST;
      fsq_q    <= square_factor(FACTOR_RST);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_WIDTH:    width_q  <= clamp_width(cfg_data_i);
        REG_HEIGHT:   height_q <= clamp_height(cfg_data_i);
        REG_FACTOR: begin
          factor_q <= factor_new;
          fsq_q    <= square_factor(factor_new);
        end
        REG_CHANNELS: chan_q   <= clamp_chan(cfg_data_i);
        default: ;
      endcase
    end
  end

  // Accumulating front end.
  boxds_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_FACTOR (MAX_FACTOR)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .restart_i  (cfg_we_i),
    .width_i    (width_q),
    .height_i   (height_q),
    .factor_i   (factor_q),
    .chan_i     (chan_q),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_data_o   (q_push_data)
  );

  // Queue of finished block sums.
  boxds_queue #(
    .DATA_W (ENTRY_W),
    .DEPTH  (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_push_data),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .pop_data_o  (q_pop_data),
    .empty_o     (q_empty)
  );

  // Dividing back end with the output register.
  boxds_back #(
    .MAX_FACTOR (MAX_FACTOR)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fsq_i       (fsq_q),
    .q_empty_i   (q_empty),
    .q_pop_o     (q_pop),
    .q_data_i    (q_pop_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// File: sim/box_average_downscaler_test.sv
// Self-checking testbench for box_average_downscaler: directed and random frames
// are checked against a cycle-free prediction of every averaged output pixel.
// Depends on boxds_pkg and the box_average_downscaler RTL.
module box_average_downscaler_test;
  timeunit 1ns;
  timeprecision 1ps;

  import boxds_pkg::*;

  localparam int unsigned SUM_DEPTH    = DEF_MAX_WIDTH / 2;
  localparam int unsigned DRAIN_CYCLES = 30;
  localparam int unsigned RANDOM_ITEMS = 460;
  localparam int unsigned CYCLE_LIMIT  = 3000000;
  localparam int unsigned PRINT_LIMIT  = 50;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  pixel_t                in_data_i;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  result_t               out_data_o;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  box_average_downscaler u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // Predicted register contents and raster position of the downscaler.
  logic [11:0] reg_width;
  logic [11:0] reg_height;
  logic [4:0]  reg_factor;
  logic [2:0]  reg_channels;
  logic [15:0] col_sum [SUM_DEPTH][4];
  logic [15:0] run_acc [4];
  logic [10:0] in_col;
  logic [10:0] in_row;
  logic [3:0]  col_in_blk;
  logic [3:0]  row_in_blk;

  result_t     expected_pixels [$];

  // Run statistics.
  int unsigned failures = 0;
  int unsigned pixels_sent = 0;
  int unsigned results_checked = 0;
  int unsigned reg_writes = 0;
  int unsigned random_pixels = 0;
  int unsigned random_setups = 0;
  int unsigned hold_offs = 0;
  int unsigned cycle_count = 0;
  int unsigned stall_hold = 0;
  bit          quiet_mode = 1'b0;

  // Clock with a 10 ns period.
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d output pixels still expected", cycle_count,
               expected_pixels.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // Gap length for either side: mostly none or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (quiet_mode) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Receiver back-pressure: free runs alternate with stall runs of random length.
  always @(posedge clk_i) begin
    if (stall_hold != 0) begin
      stall_hold <= stall_hold - 1;
    end else if (quiet_mode || out_stall_i) begin
      out_stall_i <= 1'b0;
      stall_hold <= quiet_mode ? 0 : $urandom_range(0, 12);
    end else begin
      out_stall_i <= 1'b1;
      stall_hold <= pick_gap();
    end
  end

  function automatic int unsigned clamp_range(input int unsigned v, input int unsigned lo,
                                              input int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int unsigned eff_width();
    return clamp_range(reg_width, 2, DEF_MAX_WIDTH);
  endfunction

  function automatic int unsigned eff_height();
    return clamp_range(reg_height, 2, HEIGHT_LIMIT);
  endfunction

  function automatic int unsigned eff_factor();
    return clamp_range(reg_factor, 2, DEF_MAX_FACTOR);
  endfunction

  function automatic int unsigned frame_len();
    return eff_width() * eff_height();
  endfunction

  // Any register write sends the raster position back to the top-left pixel.
  function automatic void restart_frame();
    run_acc    = '{default: '0};
    in_col     = '0;
    in_row     = '0;
    col_in_blk = '0;
    row_in_blk = '0;
  endfunction

  function automatic void reset_model();
    reg_width    = 12'(RST_WIDTH);
    reg_height   = 12'(RST_HEIGHT);
    reg_factor   = 5'(RST_FACTOR);
    reg_channels = 3'(RST_CHANNELS);
    foreach (col_sum[i, k]) col_sum[i][k] = '0;
    restart_frame();
  endfunction

  // Accumulates one accepted pixel and queues the output pixel it completes, if any.
  function automatic void accumulate_pixel(input pixel_t px);
    int unsigned w, h, f, c, ow, oh, oc, oy;
    logic [7:0]  samp [4];
    logic [15:0] blk [4];
    logic [7:0]  avg [4];
    result_t     res;
    w  = eff_width();
    h  = eff_height();
    f  = eff_factor();
    c  = clamp_range(reg_channels, 1, NUM_CH);
    ow = w / f;
    oh = h / f;
    samp = '{px.pixel_ch0, px.pixel_ch1, px.pixel_ch2, px.pixel_ch3};

    // Only pixels inside whole blocks contribute.
    if (in_col < ow * f && in_row < oh * f) begin
      for (int k = 0; k < 4; k++) begin
        if (k < c) run_acc[k] = run_acc[k] + samp[k];
      end
      if (col_in_blk == f - 1) begin
        oc = in_col / f;
        if (oc >= SUM_DEPTH) oc = SUM_DEPTH - 1;
        for (int k = 0; k < 4; k++) begin
          blk[k] = (row_in_blk == 0) ? run_acc[k] : 16'(col_sum[oc][k] + run_acc[k]);
        end
        if (row_in_blk == f - 1) begin
          // Bottom-right pixel of the block: emit the truncated average.
          oy = in_row / f;
          for (int k = 0; k < 4; k++) begin
            avg[k] = (k < c) ? 8'(blk[k] / (f * f)) : 8'd0;
          end
          res.out_ch0       = avg[0];
          res.out_ch1       = avg[1];
          res.out_ch2       = avg[2];
          res.out_ch3       = avg[3];
          res.out_x         = COORD_W'(oc);
          res.out_y         = COORD_W'(oy);
          res.last_of_frame = (oc == ow - 1 && oy == oh - 1);
          expected_pixels.push_back(res);
        end else begin
          for (int k = 0; k < 4; k++) col_sum[oc][k] = blk[k];
        end
        run_acc = '{default: '0};
      end
    end

    // Step the raster position, wrapping at the end of a line and of the frame.
    if (in_col >= w - 1) begin
      in_col     = '0;
      col_in_blk = '0;
      run_acc    = '{default: '0};
      if (in_row >= h - 1) begin
        in_row     = '0;
        row_in_blk = '0;
      end else begin
        in_row     = in_row + 1'b1;
        row_in_blk = (row_in_blk >= f - 1) ? 4'd0 : 4'(row_in_blk + 1);
      end
    end else begin
      in_col     = in_col + 1'b1;
      col_in_blk = (col_in_blk >= f - 1) ? 4'd0 : 4'(col_in_blk + 1);
    end
  endfunction

  task automatic log_failure(input string msg);
    if (failures < PRINT_LIMIT) $display("MISMATCH: %s", msg);
    failures++;
  endtask

  task automatic compare_field(input string name, input int unsigned got,
                               input int unsigned want);
    if (got != want) begin
      log_failure($sformatf("output pixel %0d field %s: got %0d, expected %0d",
                            results_checked, name, got, want));
    end
  endtask

  // Each accepted output pixel is matched against the oldest prediction.
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_pixels.size() == 0) begin
        log_failure($sformatf("unexpected output pixel at x %0d y %0d",
                              out_data_o.out_x, out_data_o.out_y));
      end else begin
        want = expected_pixels.pop_front();
        compare_field("out_ch0", out_data_o.out_ch0, want.out_ch0);
        compare_field("out_ch1", out_data_o.out_ch1, want.out_ch1);
        compare_field("out_ch2", out_data_o.out_ch2, want.out_ch2);
        compare_field("out_ch3", out_data_o.out_ch3, want.out_ch3);
        compare_field("out_x", out_data_o.out_x, want.out_x);
        compare_field("out_y", out_data_o.out_y, want.out_y);
        compare_field("last_of_frame", out_data_o.last_of_frame, want.last_of_frame);
      end
      results_checked++;
    end
  end

  // Sends one pixel after a random gap and holds it until it is accepted.
  task automatic send_pixel(input pixel_t px);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= px;
    do @(posedge clk_i); while (in_stall_o);
    accumulate_pixel(px);
    pixels_sent++;
  endtask

  function automatic pixel_t rand_pixel();
    int unsigned roll;
    roll = $urandom_range(0, 19);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return pixel_t'($urandom);
  endfunction

  // Stops sending until every predicted output pixel has arrived.
  task automatic hold_off();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (expected_pixels.size() != 0);
    @(posedge clk_i);
    hold_offs++;
  endtask

  // Leaves the block idle: no results pending and the divider given time to finish.
  task automatic drain();
    hold_off();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input int unsigned value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= CFG_DATA_W'(value);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      REG_WIDTH:    reg_width    = 12'(value);
      REG_HEIGHT:   reg_height   = 12'(value);
      REG_FACTOR:   reg_factor   = 5'(value);
      REG_CHANNELS: reg_channels = 3'(value);
      default: ;
    endcase
    restart_frame();
    reg_writes++;
  endtask

  task automatic set_format(input int unsigned w, input int unsigned h, input int unsigned f,
                            input int unsigned c);
    drain();
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_FACTOR, f);
    write_reg(REG_CHANNELS, c);
  endtask

  // Register values after reset: 640 wide, factor 2, four channels.
  // One full line plus the start of the next completes the first few blocks.
  task automatic test_reset_values();
    repeat (RST_WIDTH + 8) send_pixel(rand_pixel());
  endtask

  // Full-scale, zero, truncating and alternating-bit blocks in one 4x4 frame.
  task automatic test_block_average();
    logic [7:0] block_vals [4][4];
    logic [7:0] s;
    int unsigned b;
    block_vals = '{'{8'hFF, 8'hFF, 8'hFF, 8'hFF},
                   '{8'h00, 8'h00, 8'h00, 8'h00},
                   '{8'hFF, 8'hFF, 8'hFF, 8'hFE},
                   '{8'hAA, 8'h55, 8'h55, 8'hAA}};
    set_format(4, 4, 2, 4);
    for (int y = 0; y < 4; y++) begin
      for (int x = 0; x < 4; x++) begin
        b = (y / 2) * 2 + x / 2;
        s = block_vals[b][(y % 2) * 2 + x % 2];
        send_pixel({s, ~s, s ^ 8'h0F, s});
      end
    end
  endtask

  // Register values outside the used range are clamped.
  task automatic test_register_clamping();
    // Everything below range: 2x2 frame, factor 2, a single channel.
    set_format(0, 1, 0, 0);
    repeat (frame_len()) send_pixel(rand_pixel());
    // Factor above range acts as 16; a full-scale 16x16 block averages to 255.
    set_format(16, 16, 31, 2);
    repeat (frame_len()) send_pixel('1);
    // Factor wider than the image leaves no whole block.
    drain();
    write_reg(REG_WIDTH, 2);
    repeat (8) send_pixel(rand_pixel());
  endtask

  // Trailing columns and rows outside whole blocks, over two back-to-back frames.
  task automatic test_partial_blocks();
    set_format(7, 5, 3, 3);
    for (int i = 0; i < 2 * 35; i++) begin
      if (i == 20) hold_off();
      send_pixel(rand_pixel());
    end
  endtask

  // A register write in mid-frame restarts at the top-left pixel.
  task automatic test_frame_restart();
    set_format(6, 6, 2, 4);
    repeat (20) send_pixel(rand_pixel());
    drain();
    write_reg(REG_FACTOR, 3);
    repeat (frame_len()) send_pixel(rand_pixel());
    drain();
    write_reg(REG_FACTOR, 2);
    repeat (frame_len()) send_pixel(rand_pixel());
  endtask

  // Random small formats; mostly whole frames, some cut short by a new setup.
  task automatic test_random_frames();
    int unsigned count;
    int unsigned roll;
    while (random_pixels < RANDOM_ITEMS) begin
      drain();
      quiet_mode <= ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 1) == 1) write_reg(REG_WIDTH, $urandom_range(0, 4) == 0 ?
                                               $urandom_range(0, 40) : $urandom_range(2, 12));
      if ($urandom_range(0, 1) == 1) write_reg(REG_HEIGHT, $urandom_range(0, 4) == 0 ?
                                               $urandom_range(0, 24) : $urandom_range(2, 10));
      if ($urandom_range(0, 1) == 1) begin
        roll = $urandom_range(0, 9);
        write_reg(REG_FACTOR, roll == 0 ? $urandom_range(0, 4095) :
                              roll == 1 ? $urandom_range(6, 8) : $urandom_range(2, 5));
      end
      if ($urandom_range(0, 1) == 1) write_reg(REG_CHANNELS, $urandom_range(0, 4095));
      random_setups++;

      count = ($urandom_range(0, 9) < 7) ? frame_len() * $urandom_range(1, 2)
                                         : $urandom_range(1, frame_len());
      for (int i = 0; i < count && random_pixels < RANDOM_ITEMS; i++) begin
        if (i == count / 2 && $urandom_range(0, 9) == 0) hold_off();
        send_pixel(rand_pixel());
        random_pixels++;
      end
    end
    quiet_mode <= 1'b0;
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    cfg_we_i    = 1'b0;
    cfg_index_i = REG_WIDTH;
    cfg_data_i  = '0;
    reset_model();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_values();
    test_block_average();
    test_register_clamping();
    test_partial_blocks();
    test_frame_restart();
    test_random_frames();
    drain();

    $display("Sent %0d pixels and checked %0d output pixels over %0d register writes.",
             pixels_sent, results_checked, reg_writes);
    $display("Random part: %0d pixels over %0d formats, with %0d sender hold-offs in all.",
             random_pixels, random_setups, hold_offs);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
